/* hw/rtl/pcl_pkg.sv */
package pcl_pkg;

    localparam int MAX_VERTICES = 8;
    localparam int VIDX_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

    localparam int COORD_W  = 32;
    localparam int NUM_W    = 52;   // plane numerator, signed
    localparam int DIV_STEPS = 33;  // quotient bits; quotient <= |d| < 2^33
    localparam int STEP_W   = 6;

    localparam logic [31:0] NORMAL_Z_RESET = 32'h0001_0000;

    localparam logic [2:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] CFG_ORIGIN_Z = 3'd2;
    localparam logic [2:0] CFG_NORMAL_X = 3'd3;
    localparam logic [2:0] CFG_NORMAL_Y = 3'd4;
    localparam logic [2:0] CFG_NORMAL_Z = 3'd5;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_EMPTY  = 2'd1;
    localparam logic [1:0] STATUS_BADCNT = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BADCNT,
        ST_RD,
        ST_NUM,
        ST_DECIDE,
        ST_DEN,
        ST_LSETUP,
        ST_LMLO,
        ST_LMHI,
        ST_LSUM,
        ST_LDIV,
        ST_LRES,
        ST_EMIT_X,
        ST_EMIT_V,
        ST_ADV,
        ST_FIN
    } state_t;

endpackage

/* hw/rtl/polygon_plane_clipper.sv */
// Channel     | Handshake        | Payload
// ------------+------------------+-------------------------------------------
// s_ (vertex) | s_valid/s_ready  | s_vertex_x/y/z, s_last_vertex
// m_ (result) | m_valid/m_ready  | m_out_x/y/z, m_status, m_last_out
// cfg         | cfg_wr_en        | cfg_addr, cfg_wr_data (no wait, no read)
//
// Loading accepts one vertex per cycle. After the last vertex the closing vertex
// goes through a memory read, the plane dot product and a decision, then each
// stored vertex through a read, the dot product, a decision, an emit if kept and
// an advance. An edge that crosses the plane adds the denominator, three axes
// around a 33-step restoring divider, and the emit. The last transaction loads
// once the output is free. Reset is synchronous active low and clears control
// state and configuration only; the vertex memory is never cleared. The walk
// stalls while the output register and the pending item are both full.
module polygon_plane_clipper (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wr_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic signed [31:0] s_vertex_x,
    input  logic signed [31:0] s_vertex_y,
    input  logic signed [31:0] s_vertex_z,
    input  logic        s_last_vertex,

    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [31:0] m_out_x,
    output logic signed [31:0] m_out_y,
    output logic signed [31:0] m_out_z,
    output logic [1:0]  m_status,
    output logic        m_last_out
);
    import pcl_pkg::*;

    // configuration
    logic [31:0] origin_reg [3];
    logic [31:0] normal_reg [3];

    // vertex memory
    logic [3*COORD_W-1:0] mem [MAX_VERTICES];
    logic [3*COORD_W-1:0] rdata_reg;
    logic                 wr_en, rd_en;
    logic [VIDX_W-1:0]    rd_addr;

    // control
    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, n_reg, count_new;
    logic                too_many_reg, too_many_new;
    logic [VIDX_W-1:0]   idx_reg;
    logic                first_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [1:0]          axis_reg;
    logic                s_accept, out_free, emit_adv, idx_last;

    // datapath
    logic [31:0]         cur_c [3];
    logic [31:0]         prev_c_reg [3];
    logic [31:0]         ix_reg [3];
    logic signed [NUM_W-1:0] pn_reg, acc_reg, term;
    logic                pin_reg, cin_reg;
    logic [63:0]         prod_reg;
    logic                pneg_reg;
    logic [NUM_W-1:0]    den_mag_reg;
    logic                den_neg_reg;
    logic [50:0]         pn_mag_reg;
    logic [32:0]         a_reg;
    logic                lneg_reg;
    logic [64:0]         plo_reg;
    logic [51:0]         phi_reg;
    logic [NUM_W-1:0]    rem_reg;
    logic [32:0]         low_reg, quo_reg;

    // pending item and output register
    logic                pend_valid_reg;
    logic [31:0]         pend_c_reg [3];
    logic                m_valid_reg, m_last_reg;
    logic [31:0]         m_c_reg [3];
    logic [1:0]          m_status_reg;

    logic                out_load, out_last_d;
    logic [31:0]         out_c_d [3];
    logic [1:0]          out_status_d;
    logic                pend_load;
    logic [31:0]         pend_c_d [3];

    // combinational arithmetic
    logic signed [32:0]  num_diff, l_diff;
    logic [32:0]         num_dmag, l_dmag;
    logic [31:0]         num_nmag;
    logic [64:0]         ceil_sum;
    logic [48:0]         qmag;
    logic signed [52:0]  den_full;
    logic [84:0]         psum;
    logic [52:0]         div_t, div_sub;
    logic                div_ge;
    logic signed [33:0]  l_res;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            cur_c[k] = rdata_reg[k*COORD_W +: COORD_W];
        end
    end

    assign s_accept  = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign count_new = (count_reg < CNT_W'(MAX_VERTICES)) ? count_reg + CNT_W'(1) : count_reg;
    assign too_many_new = too_many_reg || (count_reg == CNT_W'(MAX_VERTICES));
    assign wr_en     = s_accept && (count_reg < CNT_W'(MAX_VERTICES));
    assign idx_last  = ({1'b0, idx_reg} == CNT_W'(n_reg - CNT_W'(1)));
    assign emit_adv  = !pend_valid_reg || out_free;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_reg[0] <= '0;
            origin_reg[1] <= '0;
            origin_reg[2] <= '0;
            normal_reg[0] <= '0;
            normal_reg[1] <= '0;
            normal_reg[2] <= NORMAL_Z_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_ORIGIN_X: origin_reg[0] <= cfg_wr_data;
                CFG_ORIGIN_Y: origin_reg[1] <= cfg_wr_data;
                CFG_ORIGIN_Z: origin_reg[2] <= cfg_wr_data;
                CFG_NORMAL_X: normal_reg[0] <= cfg_wr_data;
                CFG_NORMAL_Y: normal_reg[1] <= cfg_wr_data;
                CFG_NORMAL_Z: normal_reg[2] <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // vertex memory, one write port, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[count_reg[VIDX_W-1:0]] <= {s_vertex_z, s_vertex_y, s_vertex_x};
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept && s_last_vertex) begin
                    if (too_many_new || count_new < CNT_W'(2)) state_next = ST_BADCNT;
                    else                                       state_next = ST_RD;
                end
            end
            ST_BADCNT: if (out_free) state_next = ST_IDLE;
            ST_RD:     state_next = ST_NUM;
            ST_NUM:    if (step_reg == STEP_W'(3)) state_next = ST_DECIDE;
            ST_DECIDE: begin
                if (first_reg)                      state_next = ST_RD;
                else if (acc_reg[NUM_W-1] != pin_reg) state_next = ST_DEN;
                else if (acc_reg[NUM_W-1])          state_next = ST_EMIT_V;
                else                                state_next = ST_ADV;
            end
            ST_DEN:    state_next = ST_LSETUP;
            ST_LSETUP: state_next = ST_LMLO;
            ST_LMLO:   state_next = ST_LMHI;
            ST_LMHI:   state_next = ST_LSUM;
            ST_LSUM:   state_next = ST_LDIV;
            ST_LDIV:   if (step_reg == STEP_W'(DIV_STEPS - 1)) state_next = ST_LRES;
            ST_LRES:   state_next = (axis_reg == 2'd2) ? ST_EMIT_X : ST_LSETUP;
            ST_EMIT_X: if (emit_adv) state_next = cin_reg ? ST_EMIT_V : ST_ADV;
            ST_EMIT_V: if (emit_adv) state_next = ST_ADV;
            ST_ADV:    state_next = idx_last ? ST_FIN : ST_RD;
            ST_FIN:    if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_ready      = (state_reg == ST_IDLE);
        rd_en        = (state_reg == ST_RD);
        rd_addr      = first_reg ? VIDX_W'(n_reg - CNT_W'(1)) : idx_reg;
        out_load     = 1'b0;
        out_last_d   = 1'b1;
        out_status_d = STATUS_OK;
        pend_load    = 1'b0;
        for (int k = 0; k < 3; k++) begin
            out_c_d[k]  = '0;
            pend_c_d[k] = (state_reg == ST_EMIT_X) ? ix_reg[k] : cur_c[k];
        end
        case (state_reg)
            ST_EMIT_X, ST_EMIT_V: begin
                pend_load = emit_adv;
                if (pend_valid_reg && out_free) begin
                    out_load   = 1'b1;
                    out_last_d = 1'b0;
                    for (int k = 0; k < 3; k++) out_c_d[k] = pend_c_reg[k];
                end
            end
            ST_FIN: begin
                out_load = out_free;
                if (pend_valid_reg) begin
                    for (int k = 0; k < 3; k++) out_c_d[k] = pend_c_reg[k];
                end else begin
                    out_status_d = STATUS_EMPTY;
                end
            end
            ST_BADCNT: begin
                out_load     = out_free;
                out_status_d = STATUS_BADCNT;
            end
            default: ;
        endcase
    end

    // arithmetic
    always_comb begin
        num_diff = $signed({origin_reg[step_reg[1:0]][31], origin_reg[step_reg[1:0]]})
                 - $signed({cur_c[step_reg[1:0]][31], cur_c[step_reg[1:0]]});
        num_dmag = num_diff[32] ? 33'(-num_diff) : 33'(num_diff);
        num_nmag = normal_reg[step_reg[1:0]][31] ? 32'(-normal_reg[step_reg[1:0]])
                                                 : normal_reg[step_reg[1:0]];
        ceil_sum = {1'b0, prod_reg} + 65'h0_FFFF;
        qmag     = pneg_reg ? ceil_sum[64:16] : {1'b0, prod_reg[63:16]};
        term     = pneg_reg ? -$signed({3'b000, qmag}) : $signed({3'b000, qmag});

        den_full = $signed({pn_reg[NUM_W-1], pn_reg}) - $signed({acc_reg[NUM_W-1], acc_reg});

        l_diff = $signed({cur_c[axis_reg][31], cur_c[axis_reg]})
               - $signed({prev_c_reg[axis_reg][31], prev_c_reg[axis_reg]});
        l_dmag = l_diff[32] ? 33'(-l_diff) : 33'(l_diff);

        psum   = {20'b0, plo_reg} + {1'b0, phi_reg, 32'b0};

        div_t   = {rem_reg, low_reg[32]};
        div_ge  = (div_t >= {1'b0, den_mag_reg});
        div_sub = div_t - {1'b0, den_mag_reg};

        l_res = lneg_reg
              ? $signed({{2{prev_c_reg[axis_reg][31]}}, prev_c_reg[axis_reg]})
                - $signed({1'b0, quo_reg})
              : $signed({{2{prev_c_reg[axis_reg][31]}}, prev_c_reg[axis_reg]})
                + $signed({1'b0, quo_reg});
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            too_many_reg   <= 1'b0;
            first_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (s_accept) begin
                if (s_last_vertex) begin
                    count_reg    <= '0;
                    too_many_reg <= 1'b0;
                    first_reg    <= 1'b1;
                end else begin
                    count_reg    <= count_new;
                    too_many_reg <= too_many_new;
                end
            end
            if (state_reg == ST_DECIDE) first_reg <= 1'b0;
            if (pend_load)                          pend_valid_reg <= 1'b1;
            else if (state_reg == ST_FIN && out_free) pend_valid_reg <= 1'b0;
            if (out_load)     m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (s_accept && s_last_vertex) begin
            n_reg   <= count_new;
            idx_reg <= '0;
        end
        if (pend_load) begin
            for (int k = 0; k < 3; k++) pend_c_reg[k] <= pend_c_d[k];
        end
        if (out_load) begin
            for (int k = 0; k < 3; k++) m_c_reg[k] <= out_c_d[k];
            m_status_reg <= out_status_d;
            m_last_reg   <= out_last_d;
        end
        case (state_reg)
            ST_RD: step_reg <= '0;
            ST_NUM: begin
                if (step_reg != STEP_W'(3)) begin
                    prod_reg <= 64'(num_dmag * num_nmag);
                    pneg_reg <= num_diff[32] ^ normal_reg[step_reg[1:0]][31];
                end
                acc_reg  <= (step_reg == '0) ? '0 : acc_reg + term;
                step_reg <= step_reg + STEP_W'(1);
            end
            ST_DECIDE: begin
                cin_reg <= acc_reg[NUM_W-1];
                if (first_reg) begin
                    for (int k = 0; k < 3; k++) prev_c_reg[k] <= cur_c[k];
                    pn_reg  <= acc_reg;
                    pin_reg <= acc_reg[NUM_W-1];
                end
            end
            ST_DEN: begin
                den_mag_reg <= den_full[52] ? NUM_W'(-den_full) : NUM_W'(den_full);
                den_neg_reg <= den_full[52];
                pn_mag_reg  <= pn_reg[NUM_W-1] ? 51'(-pn_reg) : 51'(pn_reg);
                axis_reg    <= '0;
            end
            ST_LSETUP: begin
                a_reg    <= l_dmag;
                lneg_reg <= l_diff[32] ^ pn_reg[NUM_W-1] ^ den_neg_reg;
            end
            ST_LMLO: plo_reg <= a_reg * pn_mag_reg[31:0];
            ST_LMHI: phi_reg <= a_reg * pn_mag_reg[50:32];
            ST_LSUM: begin
                rem_reg  <= psum[84:33];
                low_reg  <= psum[32:0];
                quo_reg  <= '0;
                step_reg <= '0;
            end
            ST_LDIV: begin
                rem_reg  <= div_ge ? div_sub[NUM_W-1:0] : div_t[NUM_W-1:0];
                low_reg  <= {low_reg[31:0], 1'b0};
                quo_reg  <= {quo_reg[31:0], div_ge};
                step_reg <= step_reg + STEP_W'(1);
            end
            ST_LRES: begin
                ix_reg[axis_reg] <= l_res[31:0];
                axis_reg         <= axis_reg + 2'd1;
            end
            ST_ADV: begin
                for (int k = 0; k < 3; k++) prev_c_reg[k] <= cur_c[k];
                pn_reg  <= acc_reg;
                pin_reg <= cin_reg;
                idx_reg <= idx_reg + VIDX_W'(1);
            end
            default: ;
        endcase
    end

    assign m_valid    = m_valid_reg;
    assign m_out_x    = m_c_reg[0];
    assign m_out_y    = m_c_reg[1];
    assign m_out_z    = m_c_reg[2];
    assign m_status   = m_status_reg;
    assign m_last_out = m_last_reg;

    a_status_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != STATUS_OK) |-> m_last_out)
        else $error("status item without last flag");

    a_fin_emits_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN) && out_free |=> m_valid && m_last_out)
        else $error("polygon end did not produce a last item");

    a_no_input_while_clipping: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last_vertex |=> !s_ready)
        else $error("input taken right after last vertex");

    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("pending vertex left over in idle");

endmodule
